// ----- rtl/matrix3x3_inverse_top_macros.svh -----
// Assertion macros used by the matrix inverse RTL.
`ifndef MATRIX3X3_INVERSE_TOP_MACROS_SVH
`define MATRIX3X3_INVERSE_TOP_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define M3INV_CHECK(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Condition in one cycle that implies a result in the next cycle.
`define M3INV_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/m3inv_pkg.sv -----
// Types and constants shared by the 3x3 matrix inverse block.
package m3inv_pkg;

    localparam int ELEM_W = 32;
    localparam int CM_W   = 64;   // cofactor magnitude
    localparam int DM_W   = 96;   // determinant magnitude
    localparam int THR_W  = 63;
    localparam int QB     = 33;   // quotient bits kept after the overflow check
    localparam int QDEPTH = 16;
    localparam int QPTR_W = 4;
    localparam int QCNT_W = 5;

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [THR_W-1:0]  THR_RESET = 63'd2814750;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_r0_c0;
        logic signed [ELEM_W-1:0] elem_r1_c0;
        logic signed [ELEM_W-1:0] elem_r2_c0;
        logic signed [ELEM_W-1:0] elem_r0_c1;
        logic signed [ELEM_W-1:0] elem_r1_c1;
        logic signed [ELEM_W-1:0] elem_r2_c1;
        logic signed [ELEM_W-1:0] elem_r0_c2;
        logic signed [ELEM_W-1:0] elem_r1_c2;
        logic signed [ELEM_W-1:0] elem_r2_c2;
    } t_mat;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0_c0;
        logic signed [ELEM_W-1:0] inv_r1_c0;
        logic signed [ELEM_W-1:0] inv_r2_c0;
        logic signed [ELEM_W-1:0] inv_r0_c1;
        logic signed [ELEM_W-1:0] inv_r1_c1;
        logic signed [ELEM_W-1:0] inv_r2_c1;
        logic signed [ELEM_W-1:0] inv_r0_c2;
        logic signed [ELEM_W-1:0] inv_r1_c2;
        logic signed [ELEM_W-1:0] inv_r2_c2;
        logic                     singular;
    } t_inv;

    // A classified request: cofactors and determinant as sign and magnitude.
    typedef struct packed {
        logic [8:0][CM_W-1:0] cmag;
        logic [8:0]           csg;
        logic [DM_W-1:0]      dmag;
        logic                 dneg;
        logic                 singular;
    } t_cls;

endpackage

// ----- rtl/m3inv_if.sv -----
// Handshake channels of the matrix inverse block.
interface m3inv_mat_if;
    logic               valid;
    logic               ready;
    m3inv_pkg::t_mat    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m3inv_inv_if;
    logic               valid;
    logic               ready;
    m3inv_pkg::t_inv    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m3inv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [m3inv_pkg::THR_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/m3inv_front.sv -----
// Front pipeline: cofactors, determinant and singularity test.
module m3inv_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    m3inv_mat_if.sink                    i_mat,
    input  logic [m3inv_pkg::THR_W-1:0]  i_thr,
    input  logic                         i_pop,
    output logic                         o_valid,
    output m3inv_pkg::t_cls              o_cls
);
    import m3inv_pkg::*;

    // Operands of each cofactor x*y - z*w, elements in column-major order.
    localparam int CF_X [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Y [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_Z [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_W [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic signed [ELEM_W-1:0] el [9];
    logic                     acc;
    logic [QCNT_W-1:0]        r_cnt;
    logic [7:1]               r_v;

    logic signed [CM_W-1:0]   r1_pa [9];
    logic signed [CM_W-1:0]   r1_pb [9];
    logic signed [ELEM_W-1:0] r1_row [3];
    logic [CM_W:0]            n_d1 [9];
    logic [CM_W:0]            n_d2 [9];
    logic [ELEM_W-1:0]        n_rneg [3];

    logic [CM_W-1:0]          r_cm [2:7][9];
    logic [8:0]               r_cs [2:7];
    logic [ELEM_W-1:0]        r2_xm [3];
    logic [2:0]               r2_xs;
    logic [CM_W-1:0]          r3_pl [3];
    logic [CM_W-1:0]          r3_ph [3];
    logic [2:0]               r3_ts;
    logic [DM_W-1:0]          r4_t [3];
    logic [2:0]               r4_ts;
    logic [DM_W+1:0]          n_term [3];
    logic [DM_W+1:0]          r5_det;
    logic [DM_W+1:0]          n_dneg;
    logic [DM_W-1:0]          r6_dmag;
    logic                     r6_dneg;
    logic [DM_W-1:0]          r7_dmag;
    logic                     r7_dneg;
    logic                     r7_sing;

    assign el[0] = i_mat.data.elem_r0_c0;
    assign el[1] = i_mat.data.elem_r1_c0;
    assign el[2] = i_mat.data.elem_r2_c0;
    assign el[3] = i_mat.data.elem_r0_c1;
    assign el[4] = i_mat.data.elem_r1_c1;
    assign el[5] = i_mat.data.elem_r2_c1;
    assign el[6] = i_mat.data.elem_r0_c2;
    assign el[7] = i_mat.data.elem_r1_c2;
    assign el[8] = i_mat.data.elem_r2_c2;

    // One credit per queue slot covers every request inside this pipeline too,
    // so the pipeline itself never has to stall.
    assign i_mat.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign acc         = i_mat.valid && i_mat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v   <= '0;
        end else begin
            r_cnt <= r_cnt + QCNT_W'(acc) - QCNT_W'(i_pop);
            r_v   <= {r_v[6:1], acc};
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_d1[k] = {r1_pa[k][CM_W-1], r1_pa[k]} - {r1_pb[k][CM_W-1], r1_pb[k]};
            n_d2[k] = {r1_pb[k][CM_W-1], r1_pb[k]} - {r1_pa[k][CM_W-1], r1_pa[k]};
        end
        for (int k = 0; k < 3; k++) begin
            n_rneg[k] = ELEM_W'(-r1_row[k]);
            n_term[k] = ({2'b00, r4_t[k]} ^ {(DM_W+2){r4_ts[k]}})
                        + (DM_W+2)'(r4_ts[k]);
        end
        n_dneg = -r5_det;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r1_pa[k] <= el[CF_X[k]] * el[CF_Y[k]];
            r1_pb[k] <= el[CF_Z[k]] * el[CF_W[k]];
            r_cs[2][k] <= n_d1[k][CM_W];
            r_cm[2][k] <= n_d1[k][CM_W] ? n_d2[k][CM_W-1:0] : n_d1[k][CM_W-1:0];
        end
        r1_row[0] <= el[0];
        r1_row[1] <= el[3];
        r1_row[2] <= el[6];
        for (int s = 3; s <= 7; s++) begin
            r_cm[s] <= r_cm[s-1];
            r_cs[s] <= r_cs[s-1];
        end
        for (int k = 0; k < 3; k++) begin
            r2_xs[k] <= r1_row[k][ELEM_W-1];
            r2_xm[k] <= r1_row[k][ELEM_W-1] ? n_rneg[k] : r1_row[k];
            r3_pl[k] <= r2_xm[k] * r_cm[2][k][31:0];
            r3_ph[k] <= r2_xm[k] * r_cm[2][k][63:32];
            r3_ts[k] <= r2_xs[k] ^ r_cs[2][k];
            r4_t[k]  <= {r3_ph[k], 32'b0} + DM_W'(r3_pl[k]);
            r4_ts[k] <= r3_ts[k];
        end
        r5_det  <= n_term[0] + n_term[1] + n_term[2];
        r6_dneg <= r5_det[DM_W+1];
        r6_dmag <= r5_det[DM_W+1] ? n_dneg[DM_W-1:0] : r5_det[DM_W-1:0];
        r7_dneg <= r6_dneg;
        r7_dmag <= r6_dmag;
        r7_sing <= (r6_dmag <= DM_W'(i_thr));
    end

    assign o_valid = r_v[7];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_cls.cmag[k] = r_cm[7][k];
        end
        o_cls.csg      = r_cs[7];
        o_cls.dmag     = r7_dmag;
        o_cls.dneg     = r7_dneg;
        o_cls.singular = r7_sing;
    end

endmodule

// ----- rtl/m3inv_queue.sv -----
// Queue of classified requests between the front and back pipelines.
`include "matrix3x3_inverse_top_macros.svh"

module m3inv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  m3inv_pkg::t_cls i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output m3inv_pkg::t_cls o_data
);
    import m3inv_pkg::*;

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_n <= r_n + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_n != '0);
    assign o_data  = r_mem[r_rp];

    `M3INV_CHECK(a_no_overflow, i_clk, i_rst_n, !i_push || (r_n != QCNT_W'(QDEPTH)), "queue overflow")
    `M3INV_CHECK(a_no_underflow, i_clk, i_rst_n, !i_pop || (r_n != '0), "queue underflow")
    `M3INV_CHECK_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_n == $past(r_n) + 1'b1, "count slip")

endmodule

// ----- rtl/m3inv_back.sv -----
// Back pipeline: restoring division of the cofactors, saturation, identity for singular requests and output register.
module m3inv_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  m3inv_pkg::t_cls i_cls,
    output logic            o_pop,
    m3inv_inv_if.source     o_inv
);
    import m3inv_pkg::*;

    localparam int NW = CM_W + 2 * FRAC_BITS;
    localparam int WW = (NW > DM_W + QB + 1) ? NW : DM_W + QB + 1;
    localparam int NS = QB + 1;
    localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

    logic               en;
    logic [NS-1:0]      r_v;
    logic               r_ov;
    logic [WW-1:0]      r_rem [NS][9];
    logic [QB-1:0]      r_q   [NS][9];
    logic [DM_W-1:0]    r_dm  [NS];
    logic [8:0]         r_neg [NS];
    logic [8:0]         r_ovf [NS];
    logic [NS-1:0]      r_sing;
    logic [WW-1:0]      n_num [9];
    logic [8:0]         n_ovf;
    logic [WW:0]        n_diff [NS][9];
    logic [QB-1:0]      n_nq  [9];
    logic [ELEM_W-1:0]  n_out [9];
    logic [ELEM_W-1:0]  r_out [9];
    logic               r_osing;

    // The whole pipeline holds while a finished result is not taken.
    assign en    = !r_ov || o_inv.ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_num[k] = WW'(i_cls.cmag[k]) << (2 * FRAC_BITS);
            // A quotient of 2^QB or more saturates in either direction.
            n_ovf[k] = n_num[k] >= (WW'(i_cls.dmag) << QB);
        end
        for (int s = 0; s < NS; s++) begin
            for (int k = 0; k < 9; k++) begin
                n_diff[s][k] = '0;
            end
        end
        for (int s = 1; s < NS; s++) begin
            for (int k = 0; k < 9; k++) begin
                n_diff[s][k] = {1'b0, r_rem[s-1][k]}
                               - ({1'b0, WW'(r_dm[s-1])} << (QB - s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_rem[0][k] <= n_num[k];
                r_q[0][k]   <= '0;
            end
            r_ovf[0]  <= n_ovf;
            r_neg[0]  <= i_cls.csg ^ {9{i_cls.dneg}};
            r_dm[0]   <= i_cls.dmag;
            r_sing[0] <= i_cls.singular;
            for (int s = 1; s < NS; s++) begin
                for (int k = 0; k < 9; k++) begin
                    r_rem[s][k] <= n_diff[s][k][WW] ? r_rem[s-1][k]
                                                    : n_diff[s][k][WW-1:0];
                    r_q[s][k]   <= r_q[s-1][k]
                                   | (QB'(!n_diff[s][k][WW]) << (QB - s));
                end
                r_ovf[s]  <= r_ovf[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_dm[s]   <= r_dm[s-1];
                r_sing[s] <= r_sing[s-1];
            end
            r_out   <= n_out;
            r_osing <= r_sing[NS-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_nq[k] = -r_q[NS-1][k];
            if (r_sing[NS-1]) begin
                n_out[k] = (k == 0 || k == 4 || k == 8) ? ONE : '0;
            end else if (r_neg[NS-1][k]) begin
                n_out[k] = (r_ovf[NS-1][k] || r_q[NS-1][k] > QB'(SAT_NEG))
                           ? SAT_NEG : n_nq[k][ELEM_W-1:0];
            end else begin
                n_out[k] = (r_ovf[NS-1][k] || r_q[NS-1][k] > QB'(SAT_POS))
                           ? SAT_POS : r_q[NS-1][k][ELEM_W-1:0];
            end
        end
    end

    assign o_inv.valid          = r_ov;
    assign o_inv.data.inv_r0_c0 = r_out[0];
    assign o_inv.data.inv_r1_c0 = r_out[1];
    assign o_inv.data.inv_r2_c0 = r_out[2];
    assign o_inv.data.inv_r0_c1 = r_out[3];
    assign o_inv.data.inv_r1_c1 = r_out[4];
    assign o_inv.data.inv_r2_c1 = r_out[5];
    assign o_inv.data.inv_r0_c2 = r_out[6];
    assign o_inv.data.inv_r1_c2 = r_out[7];
    assign o_inv.data.inv_r2_c2 = r_out[8];
    assign o_inv.data.singular  = r_osing;

endmodule

// ----- rtl/matrix3x3_inverse_top.sv -----
// Top level of the 3x3 matrix inverse block.
//
// i_mat takes one 3x3 Q16.16 matrix per request (valid/ready, column-major).
// o_inv returns its inverse, each element the cofactor over the determinant,
// truncated toward zero and saturated to 32 bits. When |det| is at or below
// the threshold, the identity comes back with singular set.
// i_cfg writes the 63-bit threshold (units of 2^-3*FRAC_BITS); it is always
// ready and should only be written while no request is in flight.
// A front pipeline of 7 stages forms cofactors and determinant, a 16-entry
// queue decouples it from a 35-stage back pipeline that runs one quotient bit
// per division stage for all nine elements. One request is taken every cycle
// while i_mat ready is high. When o_inv is stalled the back pipeline holds,
// the queue fills, and i_mat ready drops once 16 requests are outstanding
// between input and queue exit. Synchronous active-low reset empties both
// pipelines and the queue, restores the threshold to 2814750 (about 1e-8).
module matrix3x3_inverse_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m3inv_mat_if.sink   i_mat,
    m3inv_cfg_if.sink   i_cfg,
    m3inv_inv_if.source o_inv
);
    import m3inv_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             f_valid;
    t_cls             f_cls;
    logic             q_valid;
    t_cls             q_cls;
    logic             b_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    m3inv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat),
        .i_thr   (r_thr),
        .i_pop   (b_pop),
        .o_valid (f_valid),
        .o_cls   (f_cls)
    );

    m3inv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_cls),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    m3inv_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_pop   (b_pop),
        .o_inv   (o_inv)
    );

endmodule

// ----- dv/tb_matrix3x3_inverse_top.sv -----
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_top;
    import m3inv_pkg::*;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 1330;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic i_clk;
    logic i_rst_n;
    m3inv_mat_if mat_ch();
    m3inv_inv_if inv_ch();
    m3inv_cfg_if cfg_ch();

    matrix3x3_inverse_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_inv  (inv_ch.source)
    );

    logic [THR_W-1:0] threshold;
    t_inv             inverse_queue[$];
    int               error_count;
    int               cycle_count;
    int               sender_idle_pct;
    int               receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Quotient of cofactor over determinant, truncated and saturated.
    function automatic logic [31:0] div_sat(logic [63:0] cmag, logic cneg,
                                            logic [127:0] dmag, logic dneg);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, cmag} << (2 * FRAC);
        q = num / dmag;
        if (cneg != dneg) begin
            if (q > 128'h8000_0000) return 32'h8000_0000;
            return 32'(-q);
        end
        if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_inv invert_matrix(t_mat m);
        logic signed [127:0] a, b, c, d, e, f, g, h, k;
        logic signed [127:0] cof[9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [31:0]         o[9];
        t_inv                r;
        a = m.elem_r0_c0; b = m.elem_r1_c0; c = m.elem_r2_c0;
        d = m.elem_r0_c1; e = m.elem_r1_c1; f = m.elem_r2_c1;
        g = m.elem_r0_c2; h = m.elem_r1_c2; k = m.elem_r2_c2;
        cof[0] = e * k - f * h;
        cof[1] = c * h - b * k;
        cof[2] = b * f - c * e;
        cof[3] = f * g - d * k;
        cof[4] = a * k - c * g;
        cof[5] = c * d - a * f;
        cof[6] = d * h - e * g;
        cof[7] = b * g - a * h;
        cof[8] = a * e - b * d;
        det = a * cof[0] + d * cof[1] + g * cof[2];
        dmag = det < 0 ? -det : det;
        if (dmag <= {65'd0, threshold}) begin
            foreach (o[j]) o[j] = (j % 4 == 0) ? (32'd1 << FRAC) : 32'd0;
            r.singular = 1'b1;
        end else begin
            foreach (o[j]) begin
                o[j] = div_sat(cof[j] < 0 ? 64'(-cof[j]) : 64'(cof[j]), cof[j] < 0,
                               dmag, det < 0);
            end
            r.singular = 1'b0;
        end
        r.inv_r0_c0 = o[0]; r.inv_r1_c0 = o[1]; r.inv_r2_c0 = o[2];
        r.inv_r0_c1 = o[3]; r.inv_r1_c1 = o[4]; r.inv_r2_c1 = o[5];
        r.inv_r0_c2 = o[6]; r.inv_r1_c2 = o[7]; r.inv_r2_c2 = o[8];
        return r;
    endfunction

    // Receiver: random stall, compare every result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inv_ch.ready <= 1'b0;
        end else begin
            if (inv_ch.valid && inv_ch.ready) begin
                if (inverse_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, inv_ch.data);
                    error_count++;
                end else begin
                    t_inv want;
                    want = inverse_queue.pop_front();
                    if (want !== inv_ch.data) begin
                        $display("%0t: expected %h actual %h", $time, want, inv_ch.data);
                        error_count++;
                    end
                end
            end
            inv_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic wait_idle();
        mat_ch.valid <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        threshold = value;
    endtask

    // Drives one matrix; the prediction is queued when the request is accepted.
    // Valid stays high after acceptance so that requests can follow back to back.
    // An optional directly known result is checked against the predictor.
    task automatic send_matrix(t_mat m, bit known = 0, t_inv known_inv = '0);
        t_inv pred;
        while ($urandom_range(99) < sender_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pred = invert_matrix(m);
        if (known && pred !== known_inv) begin
            $display("%0t: expected %h actual %h (predictor)", $time, known_inv, pred);
            error_count++;
        end
        mat_ch.valid <= 1'b1;
        mat_ch.data  <= m;
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
        inverse_queue.push_back(pred);
    endtask

    function automatic t_mat diag(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_mat m;
        m = '0;
        m.elem_r0_c0 = x; m.elem_r1_c1 = y; m.elem_r2_c2 = z;
        return m;
    endfunction

    function automatic t_inv diag_inv(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic sing);
        t_inv r;
        r = '0;
        r.inv_r0_c0 = x; r.inv_r1_c1 = y; r.inv_r2_c2 = z; r.singular = sing;
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        logic [31:0] e[9];
        foreach (e[j]) e[j] = rand_elem();
        // Some matrices get a repeated column, which makes them singular.
        if ($urandom_range(9) == 0) begin
            e[3] = e[0]; e[4] = e[1]; e[5] = e[2];
        end
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    initial begin
        t_mat        dir_mat[$];
        t_inv        dir_inv[$];
        bit          dir_known[$];
        t_mat        m;
        logic [31:0] one;
        t_idle       phase;
        one = 32'd1 << FRAC;
        error_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        threshold = THR_RESET;
        i_rst_n = 1'b0;
        mat_ch.valid = 1'b0;
        mat_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: identity, zero, scaled diagonals, saturation, extremes.
        dir_mat.push_back(diag(one, one, one));
        dir_inv.push_back(diag_inv(one, one, one, 0)); dir_known.push_back(1);
        dir_mat.push_back('0);
        dir_inv.push_back(diag_inv(one, one, one, 1)); dir_known.push_back(1);
        dir_mat.push_back(diag(2 * one, 4 * one, -one));
        dir_inv.push_back(diag_inv(one / 2, one / 4, -one, 0)); dir_known.push_back(1);
        // Determinant 2^22 units clears the reset threshold; tiny pivots saturate.
        dir_mat.push_back(diag(1, 1, 64 * one));
        dir_inv.push_back(diag_inv(32'h7FFF_FFFF, 32'h7FFF_FFFF, one / 64, 0));
        dir_known.push_back(1);
        dir_mat.push_back(diag(-1, 1, 64 * one));
        dir_inv.push_back(diag_inv(32'h8000_0000, 32'h7FFF_FFFF, one / 64, 0));
        dir_known.push_back(1);
        dir_mat.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_inv.push_back('0); dir_known.push_back(0);
        dir_mat.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir_inv.push_back('0); dir_known.push_back(0);
        dir_mat.push_back({9{32'h8000_0000}});
        dir_inv.push_back(diag_inv(one, one, one, 1)); dir_known.push_back(1);
        dir_mat.push_back({9{32'hFFFF_FFFF}});
        dir_inv.push_back(diag_inv(one, one, one, 1)); dir_known.push_back(1);
        dir_mat.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF});
        dir_inv.push_back('0); dir_known.push_back(0);
        dir_mat.push_back({one, 2 * one, 3 * one, 32'd0, one, 4 * one, 5 * one, 6 * one,
                           32'd0});
        dir_inv.push_back('0); dir_known.push_back(0);
        dir_mat.push_back({32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h8765_4321,
                           32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3C3C_3C3C, 32'hC3C3_C3C3,
                           32'h7777_7777});
        dir_inv.push_back('0); dir_known.push_back(0);
        // Determinant of 1 unit sits below the reset threshold.
        dir_mat.push_back(diag(1, 1, 1));
        dir_inv.push_back(diag_inv(one, one, one, 1)); dir_known.push_back(1);
        foreach (dir_mat[j]) send_matrix(dir_mat[j], dir_known[j], dir_inv[j]);
        wait_idle();

        // Threshold extremes: zero, with a near-singular case, and maximum.
        write_threshold('0);
        send_matrix(diag(1, 1, 1));
        send_matrix('0, 1, diag_inv(one, one, one, 1));
        wait_idle();
        write_threshold('1);
        send_matrix(diag(one, one, one), 1, diag_inv(one, one, one, 1));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            phase = t_idle'(p % 4);
            case (phase)
                IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                IDLE_SENDER:   begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                IDLE_BOTH:     begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase
            case (p % 4)
                0: write_threshold(THR_RESET);
                1: write_threshold(63'd1 << $urandom_range(62));
                2: write_threshold('0);
                default: write_threshold(63'({$urandom, $urandom}));
            endcase
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                send_matrix(rand_matrix());
                // Hold off once until the pipeline has drained completely.
                if (p == 1 && n == 40) begin
                    mat_ch.valid <= 1'b0;
                    while (inverse_queue.size() != 0) @(posedge i_clk);
                end
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/m3inv_pkg.sv
rtl/m3inv_if.sv
rtl/m3inv_front.sv
rtl/m3inv_queue.sv
rtl/m3inv_back.sv
rtl/matrix3x3_inverse_top.sv
dv/tb_matrix3x3_inverse_top.sv
